// ===== sv/skip_mask_run_finder_top_defines.svh =====
`ifndef SKIP_MASK_RUN_FINDER_TOP_DEFINES_SVH
`define SKIP_MASK_RUN_FINDER_TOP_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define SMRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the following cycle.
`define SMRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/smrf_pkg.sv =====
`timescale 1ns / 1ps

package smrf_pkg;

    // Field widths of the words on the ports.
    localparam int BYTE_W       = 8;
    localparam int INDEX_W      = 8;
    localparam int RUN_START_W  = 11;
    localparam int RUN_LENGTH_W = 13;
    localparam int TOTAL_W      = 12;
    localparam int CFG_W        = 9;

    // Default store depth and reset value of the mask length register.
    localparam int MASK_BYTES_DEF = 256;
    localparam int CFG_RESET      = 256;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control from the sequencer to the byte scan unit.
    typedef struct packed {
        logic clear;
        logic byte_valid;
    } scan_ctrl_t;

endpackage

// ===== sv/smrf_mask_mem.sv =====
`timescale 1ns / 1ps

module smrf_mask_mem #(
    parameter int DEPTH = smrf_pkg::MASK_BYTES_DEF,
    parameter int AW    = 8
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             wr_addr,
    input  logic [smrf_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [smrf_pkg::BYTE_W-1:0] rd_data
);
    import smrf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/smrf_scan_unit.sv =====
`timescale 1ns / 1ps

module smrf_scan_unit #(
    parameter int MASK_BYTES = smrf_pkg::MASK_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smrf_pkg::scan_ctrl_t                ctrl,
    input  logic [smrf_pkg::BYTE_W-1:0]         byte_data,
    input  logic [smrf_pkg::RUN_START_W-1:0]    run_start,
    output logic signed [smrf_pkg::RUN_LENGTH_W-1:0] run_length,
    output logic [smrf_pkg::TOTAL_W-1:0]        total_set_bits
);
    import smrf_pkg::*;

    localparam int IDX_W        = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
    localparam int START_BYTE_W = RUN_START_W - 3;
    localparam int CMP_W        = (IDX_W > START_BYTE_W) ? IDX_W : START_BYTE_W;

    logic [IDX_W-1:0]        byte_idx_reg, byte_idx_next;
    logic                    started_reg, started_next;
    logic                    active_reg, active_next;
    logic                    want_reg, want_next;
    logic [RUN_LENGTH_W-1:0] len_reg, len_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;

    // One mask byte per cycle while byte_valid is set: eight bit steps, most significant bit first.
    always_comb
    begin
        logic                    st;
        logic                    ac;
        logic                    wt;
        logic                    b;
        logic                    hit;
        logic [RUN_LENGTH_W-1:0] ln;
        logic [3:0]              ones;
        st   = started_reg;
        ac   = active_reg;
        wt   = want_reg;
        ln   = len_reg;
        ones = '0;
        hit  = (CMP_W'(byte_idx_reg) == CMP_W'(run_start[RUN_START_W-1:3]));
        for (int k = 0; k < BYTE_W; k++)
        begin
            b    = byte_data[BYTE_W-1-k];
            ones = ones + 4'(b);
            if (!st && hit && (3'(k) == run_start[2:0]))
            begin
                st = 1'b1;
                ac = 1'b1;
                wt = b;
                ln = RUN_LENGTH_W'(1);
            end
            else if (st && ac)
            begin
                if (b == wt)
                begin
                    ln = ln + RUN_LENGTH_W'(1);
                end
                else
                begin
                    ac = 1'b0;
                end
            end
        end

        byte_idx_next = byte_idx_reg;
        started_next  = started_reg;
        active_next   = active_reg;
        want_next     = want_reg;
        len_next      = len_reg;
        total_next    = total_reg;
        if (ctrl.clear)
        begin
            byte_idx_next = '0;
            started_next  = 1'b0;
            active_next   = 1'b0;
            want_next     = 1'b0;
            len_next      = '0;
            total_next    = '0;
        end
        else if (ctrl.byte_valid)
        begin
            byte_idx_next = byte_idx_reg + IDX_W'(1);
            started_next  = st;
            active_next   = ac;
            want_next     = wt;
            len_next      = ln;
            total_next    = total_reg + TOTAL_W'(ones);
        end
    end

    // Scan state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= '0;
            started_reg  <= 1'b0;
            active_reg   <= 1'b0;
            want_reg     <= 1'b0;
            len_reg      <= '0;
            total_reg    <= '0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            started_reg  <= started_next;
            active_reg   <= active_next;
            want_reg     <= want_next;
            len_reg      <= len_next;
            total_reg    <= total_next;
        end
    end

    // A run of zeros is reported negated.
    assign run_length     = want_reg ? $signed(len_reg) : $signed(RUN_LENGTH_W'(0) - len_reg);
    assign total_set_bits = total_reg;

endmodule

// ===== sv/skip_mask_run_finder_top.sv =====
`timescale 1ns / 1ps

// Skip mask run finder. After reset the block sweeps the mask store to zero,
// one byte a cycle, so in_ready stays low until the sweep ends. A write word
// goes to the done state and its result is loaded into the output register
// once that register is free. A query word reads the used part of the store
// (the configured mask length saturated to MASK_BYTES) through the single
// read port, one byte a cycle, then passes the drain and done states; an
// empty mask skips the scan. One word is in work at a time; a finished
// result waits in the output register while the next word is accepted.
module skip_mask_run_finder_top #(
    parameter int MASK_BYTES = smrf_pkg::MASK_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [smrf_pkg::INDEX_W-1:0]        store_index,
    input  logic [smrf_pkg::BYTE_W-1:0]         mask_byte,
    input  logic [smrf_pkg::RUN_START_W-1:0]    run_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [smrf_pkg::RUN_LENGTH_W-1:0] run_length,
    output logic [smrf_pkg::TOTAL_W-1:0]        total_set_bits,
    output logic                                status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smrf_pkg::CFG_W-1:0]          cfg_data
);
    import smrf_pkg::*;

`include "skip_mask_run_finder_top_defines.svh"

    localparam int AW         = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;
    localparam int DEPTH_W    = $clog2(MASK_BYTES + 1);
    localparam int LEN_W      = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
    localparam int WIDE_W     = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int RESET_USED = (CFG_RESET > MASK_BYTES) ? MASK_BYTES : CFG_RESET;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            clr_addr_reg;
    logic [LEN_W-1:0]         used_reg;
    logic [LEN_W-1:0]         scan_addr_reg;
    logic [RUN_START_W-1:0]   start_reg;
    logic                     is_query_reg;
    logic                     pend_status_reg;
    logic                     rd_valid_reg;
    logic                     out_valid_reg;
    logic [RUN_LENGTH_W-1:0]  run_length_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     status_reg;

    logic                     accept;
    logic                     write_ok;
    logic                     clear_last;
    logic                     scan_last;
    logic [LEN_W-1:0]         cfg_ext;
    logic [WIDE_W-1:0]        idx_wide;
    logic                     mem_we;
    logic [AW-1:0]            mem_wr_addr;
    logic [BYTE_W-1:0]        mem_wr_data;
    logic                     mem_rd_en;
    logic [BYTE_W-1:0]        mem_rd_data;
    logic                     load_out;
    scan_ctrl_t               scan_ctrl;
    logic signed [RUN_LENGTH_W-1:0] scan_run;
    logic [TOTAL_W-1:0]       scan_total;

    assign accept     = in_valid && in_ready;
    assign write_ok   = (LEN_W'(store_index) < used_reg);
    assign clear_last = (clr_addr_reg == AW'(MASK_BYTES - 1));
    assign scan_last  = ((scan_addr_reg + LEN_W'(1)) == used_reg);
    assign cfg_ext    = LEN_W'(cfg_data);
    assign idx_wide   = WIDE_W'(store_index);
    assign cfg_ready  = 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_QUERY && used_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready             = 1'b0;
        mem_we               = 1'b0;
        mem_wr_addr          = idx_wide[AW-1:0];
        mem_wr_data          = mask_byte;
        mem_rd_en            = 1'b0;
        load_out             = 1'b0;
        scan_ctrl.clear      = 1'b0;
        scan_ctrl.byte_valid = rd_valid_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
            end
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                mem_we          = accept && (operation == OP_WRITE) && write_ok;
                scan_ctrl.clear = accept;
            end
            ST_SCAN:
            begin
                mem_rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    // State, counters and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            used_reg      <= LEN_W'(RESET_USED);
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= mem_rd_en;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (accept)
            begin
                scan_addr_reg <= '0;
            end
            else if (mem_rd_en)
            begin
                scan_addr_reg <= scan_addr_reg + LEN_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                used_reg <= (cfg_ext > LEN_W'(MASK_BYTES)) ? LEN_W'(MASK_BYTES) : cfg_ext;
            end
        end
    end

    // Details of the word in work.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg       <= run_start;
            is_query_reg    <= (operation == OP_QUERY);
            pend_status_reg <= (operation == OP_WRITE && !write_ok) ? STATUS_BAD_INDEX
                                                                     : STATUS_OK;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            run_length_reg <= is_query_reg ? scan_run : '0;
            total_reg      <= is_query_reg ? scan_total : '0;
            status_reg     <= is_query_reg ? STATUS_OK : pend_status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign run_length     = $signed(run_length_reg);
    assign total_set_bits = total_reg;
    assign status         = status_reg;

    smrf_mask_mem #(
        .DEPTH (MASK_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_addr_reg[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    smrf_scan_unit #(
        .MASK_BYTES (MASK_BYTES)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (scan_ctrl),
        .byte_data      (mem_rd_data),
        .run_start      (start_reg),
        .run_length     (scan_run),
        .total_set_bits (scan_total)
    );

    // Consistency checks.
    `SMRF_ASSERT_IMP(a_we_source, mem_we, (state_reg == ST_CLEAR) || (accept && operation == OP_WRITE), "store written outside clearing or a write word")
    `SMRF_ASSERT_NEXT(a_query_path, accept && operation == OP_QUERY, state_reg == ST_SCAN || state_reg == ST_DONE, "query word did not enter the scan")
    `SMRF_ASSERT_IMP(a_read_in_scan, rd_valid_reg, state_reg == ST_DRAIN || state_reg == ST_SCAN, "read data arrived outside a scan")
    `SMRF_ASSERT_IMP(a_bad_zero, out_valid_reg && status_reg == STATUS_BAD_INDEX, run_length_reg == '0 && total_reg == '0, "rejected write carries nonzero results")

endmodule

// ===== bench/mask_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the skip mask run finder, keeps its own copy
// of the mask store and the length register, and checks every result word
// against the oldest prediction still awaited.
module mask_result_checker
    import smrf_pkg::*;
#(
    parameter int MASK_BYTES = MASK_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           operation,
    input  logic [INDEX_W-1:0]             store_index,
    input  logic [BYTE_W-1:0]              mask_byte,
    input  logic [RUN_START_W-1:0]         run_start,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [RUN_LENGTH_W-1:0] run_length,
    input  logic [TOTAL_W-1:0]             total_set_bits,
    input  logic                           status,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [CFG_W-1:0]               cfg_data,
    output int                             pending_results,
    output int                             mismatch_count
);

    typedef struct packed {
        logic signed [RUN_LENGTH_W-1:0] run;
        logic [TOTAL_W-1:0]             total;
        logic                           status;
    } mask_result_t;

    logic [BYTE_W-1:0] mask_mirror [MASK_BYTES];
    logic [CFG_W-1:0]  mask_length_mirror;
    mask_result_t      awaited_results [$];

    initial mismatch_count = 0;

    // Prints one line for a failed check and counts it.
    task automatic report_mismatch(string what, int got, int wanted);
        begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                     wanted);
            mismatch_count++;
        end
    endtask

    // Applies one input word to the mirrored store and works out its result.
    function automatic mask_result_t predict_mask_word(logic op, logic [INDEX_W-1:0] idx,
                                                       logic [BYTE_W-1:0] val,
                                                       logic [RUN_START_W-1:0] start);
        int           used;
        int           limit;
        int           len;
        logic         first_bit;
        mask_result_t r;
        begin
            used = (mask_length_mirror > MASK_BYTES) ? MASK_BYTES : int'(mask_length_mirror);
            r = '0;
            if (op == OP_WRITE) begin
                if (idx < used)
                    mask_mirror[idx] = val;
                else
                    r.status = STATUS_BAD_INDEX;
            end else begin
                r.status = STATUS_OK;
                limit = used * 8;
                if (start < limit) begin
                    // The run stops at the first differing bit or the end of the used mask.
                    first_bit = mask_mirror[start / 8][7 - (start % 8)];
                    len = 0;
                    for (int p = start; p < limit; p++) begin
                        if (mask_mirror[p / 8][7 - (p % 8)] != first_bit)
                            break;
                        len++;
                    end
                    r.run = first_bit ? RUN_LENGTH_W'(len) : RUN_LENGTH_W'(-len);
                end
                for (int i = 0; i < used; i++)
                    r.total += TOTAL_W'($countones(mask_mirror[i]));
            end
            return r;
        end
    endfunction

    // Follows each handshake: register writes, result words, then input words.
    always @(posedge clk or negedge rst_n)
    begin
        mask_result_t oldest;
        if (!rst_n)
        begin
            for (int i = 0; i < MASK_BYTES; i++)
                mask_mirror[i] = '0;
            mask_length_mirror = CFG_W'(CFG_RESET);
            awaited_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mask_length_mirror = cfg_data;

            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result word with none awaited", 0, 0);
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (run_length !== oldest.run)
                        report_mismatch("run_length", run_length, oldest.run);
                    if (total_set_bits !== oldest.total)
                        report_mismatch("total_set_bits", total_set_bits, oldest.total);
                    if (status !== oldest.status)
                        report_mismatch("status", status, oldest.status);
                end
            end

            if (in_valid && in_ready)
                awaited_results.push_back(predict_mask_word(operation, store_index, mask_byte,
                                                            run_start));

            pending_results <= awaited_results.size();
        end
    end

endmodule

// ===== bench/skip_mask_run_finder_top_tb.sv =====
`timescale 1ns / 1ps

// Drives the skip mask run finder through directed and random words under
// several mask lengths and gives the verdict from the checker's count.
module skip_mask_run_finder_top_tb;

    import smrf_pkg::*;

    localparam int MASK_BYTES     = MASK_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 90;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           operation;
    logic [INDEX_W-1:0]             store_index;
    logic [BYTE_W-1:0]              mask_byte;
    logic [RUN_START_W-1:0]         run_start;
    logic                           out_valid;
    logic                           out_ready;
    logic signed [RUN_LENGTH_W-1:0] run_length;
    logic [TOTAL_W-1:0]             total_set_bits;
    logic                           status;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_W-1:0]               cfg_data;

    int pending_results;
    int mismatch_count;
    int quiet_cycles;
    int used_bytes;
    int burst_left;

    skip_mask_run_finder_top #(
        .MASK_BYTES(MASK_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .store_index(store_index),
        .mask_byte(mask_byte),
        .run_start(run_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .run_length(run_length),
        .total_set_bits(total_set_bits),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    mask_result_checker #(
        .MASK_BYTES(MASK_BYTES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .store_index(store_index),
        .mask_byte(mask_byte),
        .run_start(run_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .run_length(run_length),
        .total_set_bits(total_set_bits),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .pending_results(pending_results),
        .mismatch_count(mismatch_count)
    );

    always #10 clk = ~clk;

    // The receiver stalls in spans of its own: always ready, mostly ready,
    // mostly stalled, or a fixed four-in-twelve stall.
    initial
    begin
        int mode;
        int span;
        out_ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((c % 12) < 8);
                endcase
            end
        end
    end

    // Ends the run when no channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offers one word and holds it until accepted; the sender then keeps to
    // bursts of random length with random gaps.
    task automatic send_word(logic op, int idx, int val, int start);
        int gap;
        begin
            in_valid    <= 1'b1;
            operation   <= op;
            store_index <= INDEX_W'(idx);
            mask_byte   <= BYTE_W'(val);
            run_start   <= RUN_START_W'(start);
            do @(posedge clk); while (!in_ready);
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 30);
            end
        end
    endtask

    // Holds the sender off until every awaited result word has come.
    task automatic wait_for_results;
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (pending_results != 0);
        end
    endtask

    // Writes the mask length register while the block is idle.
    task automatic write_mask_length(int len);
        begin
            wait_for_results();
            cfg_valid <= 1'b1;
            cfg_data  <= CFG_W'(len);
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            used_bytes = (len > MASK_BYTES) ? MASK_BYTES : len;
        end
    endtask

    // Picks a mask byte that tends to build long runs of equal bits.
    function automatic int pick_mask_byte();
        begin
            case ($urandom_range(0, 5))
                0, 1:    return 8'h00;
                2, 3:    return 8'hFF;
                4:       return $urandom_range(0, 255);
                default: return ($urandom_range(0, 1) != 0) ? (8'hFF >> $urandom_range(1, 7))
                                                             : (8'hFF << $urandom_range(1, 7));
            endcase
        end
    endfunction

    // Random words for one mask length: mostly writes inside the used mask
    // and queries that start inside it, with some out-of-range noise.
    task automatic random_phase(int words);
        int limit;
        int idx;
        int start;
        begin
            limit = used_bytes * 8;
            for (int n = 0; n < words; n++)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    if (used_bytes > 0 && $urandom_range(0, 6) != 0)
                        idx = $urandom_range(0, used_bytes - 1);
                    else
                        idx = $urandom_range(0, 255);
                    send_word(OP_WRITE, idx, pick_mask_byte(), $urandom_range(0, 2047));
                end
                else
                begin
                    if (limit > 0 && $urandom_range(0, 4) != 0)
                        start = $urandom_range(0, limit - 1);
                    else
                        start = $urandom_range(0, 2047);
                    send_word(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255), start);
                end
            end
        end
    endtask

    initial
    begin
        int lengths [] = '{256, 3, 1, 17, 0, 64, 2, 255, 8, 257, 511, 128, 5, 256};
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= OP_WRITE;
        store_index <= '0;
        mask_byte   <= '0;
        run_start   <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        used_bytes = CFG_RESET;
        burst_left = $urandom_range(1, 30);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full mask from reset: empty store, both ends, ignored fields.
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, 2047);
        send_word(OP_WRITE, 0, 8'hFF, 0);
        send_word(OP_WRITE, 255, 8'h01, 0);
        send_word(OP_WRITE, 128, 8'hAA, 0);
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, 8);
        send_word(OP_QUERY, 0, 0, 2047);
        send_word(OP_QUERY, 0, 0, 1024);
        send_word(OP_QUERY, 0, 0, 1025);
        send_word(OP_WRITE, 7, 8'h0F, 2047);
        send_word(OP_QUERY, 255, 8'hFF, 56);

        // Empty mask: every write refused, nothing to count or scan.
        write_mask_length(0);
        send_word(OP_WRITE, 0, 8'hFF, 0);
        send_word(OP_QUERY, 0, 0, 0);

        // Oversized length saturates to the store depth.
        write_mask_length(511);
        send_word(OP_QUERY, 0, 0, 2047);
        send_word(OP_WRITE, 255, 8'h00, 0);
        send_word(OP_QUERY, 0, 0, 2040);

        // Two bytes: a run that ends at the end of the mask, a start beyond it.
        write_mask_length(2);
        send_word(OP_WRITE, 1, 8'hFF, 0);
        send_word(OP_WRITE, 2, 8'hFF, 0);
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, 16);
        send_word(OP_QUERY, 0, 0, 15);

        write_mask_length(1);
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_WRITE, 1, 8'h00, 0);

        // Random words under each mask length in turn.
        foreach (lengths[i])
        begin
            write_mask_length(lengths[i]);
            random_phase(PHASE_WORDS);
        end

        // Let any stray result word show itself before the verdict.
        wait_for_results();
        repeat (MASK_BYTES + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
